FILE: sv/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

	localparam int SLOTS         = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int SLOT_W        = $clog2(SLOTS);

	localparam logic [15:0] TIME_MAX = 16'hFFFF;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// One incoming transaction
	typedef struct packed {
		op_t         operation;
		logic [3:0]  slot;
		logic [15:0] arrival_time;
		logic [15:0] burst_length;
		logic [7:0]  priority_level;
	} command_t;

	// One outgoing transaction
	typedef struct packed {
		logic [15:0] tick_time;
		logic [3:0]  running_slot;
		logic        idle;
		logic        switched;
		logic        finished;
		logic [15:0] turnaround;
		logic [15:0] wait_ticks;
		logic        all_done;
	} report_t;

	// Static description of one task slot
	typedef struct packed {
		logic [15:0]              arrival;
		logic [15:0]              burst;
		logic [PRIORITY_BITS-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Scan step presented to the selection unit
	typedef struct packed {
		logic              clear;
		logic              step;
		logic [SLOT_W-1:0] idx;
		logic              active;
		logic [15:0]       now;
	} pick_ctrl_t;

	// Best candidate held by the selection unit
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
		entry_t            entry;
	} pick_t;

endpackage
`default_nettype wire

FILE: sv/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/pps_pick.sv
// Shared compare unit that keeps the best ready slot seen during a scan.
`default_nettype none
module pps_pick (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pps_pkg::pick_ctrl_t ctrl,
	input  wire pps_pkg::entry_t    entry,
	output pps_pkg::pick_t          best
);
	import pps_pkg::*;

	logic              found_q;
	logic [SLOT_W-1:0] idx_q;
	entry_t            entry_q;
	logic              arrived;
	logic              better;
	logic              take;

	// Ready test and ordering: priority, then arrival; ascending scan settles slot order
	always_comb begin
		arrived = entry.arrival <= ctrl.now;
		better  = !found_q || (entry.prio < entry_q.prio) ||
			((entry.prio == entry_q.prio) && (entry.arrival < entry_q.arrival));
		take    = ctrl.step && ctrl.active && arrived && better;
	end

	// Hold the current best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q   <= ctrl.idx;
			entry_q <= entry;
		end
	end

	assign best = '{found: found_q, idx: idx_q, entry: entry_q};

endmodule
`default_nettype wire

FILE: sv/preemptive_priority_scheduler.sv
// Timing: a load transaction is written at its accepting edge and gives no report.
// A tick stays busy through the scan, drain, remaining-work read, update (skipped when
// idle) and report states; the scan feeds one compare unit from the task RAM one slot per
// cycle. The report strobe follows in the next cycle and a new command is accepted in that cycle.
// Reset clears time, the remaining-work flags and the previous slot; the task
// RAMs are not cleared. The receiver cannot stall the report.
`default_nettype none
module preemptive_priority_scheduler (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire pps_pkg::command_t command,
	output logic                   report_valid,
	output pps_pkg::report_t       report
);
	import pps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_READ_REM,
		ST_UPDATE,
		ST_REPORT
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic              cmp_vld_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;
	logic [15:0]       time_q;
	logic [15:0]       now_q;
	logic [15:0]       ended_q;
	logic [15:0]       turn_q;
	logic              fin_q;
	logic [SLOT_W-1:0] prev_idx_q;
	logic              prev_vld_q;
	logic [SLOTS-1:0]  active_q;
	logic              report_valid_q;
	report_t           report_q;

	logic              take;
	logic              load_ok;
	logic              tick_take;
	logic [SLOT_W-1:0] load_idx;
	entry_t            load_entry;
	entry_t            task_rd;
	logic [15:0]       rem_rd;
	logic [15:0]       rem_dec;
	logic              rem_we;
	logic [SLOT_W-1:0] rem_waddr;
	logic [15:0]       rem_wdata;
	pick_ctrl_t        pick_ctrl;
	pick_t             pick;
	logic [15:0]       sub_a;
	logic [15:0]       sub_b;
	logic [16:0]       sub_d;
	logic [15:0]       wait_val;
	logic              sw;

	// Decode the incoming transaction
	always_comb begin
		take       = start && !busy;
		load_ok    = take && (command.operation == OP_LOAD) && (32'(command.slot) < SLOTS);
		tick_take  = take && (command.operation == OP_TICK);
		load_idx   = SLOT_W'(command.slot);
		load_entry = '{arrival: command.arrival_time, burst: command.burst_length,
			prio: PRIORITY_BITS'(command.priority_level)};
	end

	// Static task data, read one slot per scan cycle
	pps_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_task_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (load_idx),
		.wdata (load_entry),
		.raddr (rd_idx_q),
		.rdata (task_rd)
	);

	// Remaining work, written by loads and by the update step
	always_comb begin
		rem_dec   = rem_rd - 16'd1;
		rem_we    = load_ok || (state_q == ST_UPDATE);
		rem_waddr = load_ok ? load_idx : pick.idx;
		rem_wdata = load_ok ? command.burst_length : rem_dec;
	end

	pps_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (pick.idx),
		.rdata (rem_rd)
	);

	// Selection unit fed one slot per cycle; its slot index is registered like the RAM read data
	always_comb begin
		pick_ctrl = '{clear: tick_take, step: cmp_vld_s1, idx: cmp_idx_s1,
			active: active_q[cmp_idx_s1], now: now_q};
	end

	pps_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pick_ctrl),
		.entry  (task_rd),
		.best   (pick)
	);

	// Shared subtractor: turnaround in update, wait in report
	always_comb begin
		sub_a    = (state_q == ST_REPORT) ? turn_q : ended_q;
		sub_b    = (state_q == ST_REPORT) ? pick.entry.burst : pick.entry.arrival;
		sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
		wait_val = sub_d[16] ? 16'd0 : sub_d[15:0];
		sw       = pick.found && (!prev_vld_q || (prev_idx_q != pick.idx));
	end

	// Sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_idx_q       <= '0;
			cmp_vld_s1     <= 1'b0;
			cmp_idx_s1     <= '0;
			time_q         <= '0;
			now_q          <= '0;
			ended_q        <= '0;
			turn_q         <= '0;
			fin_q          <= 1'b0;
			prev_idx_q     <= '0;
			prev_vld_q     <= 1'b0;
			active_q       <= '0;
			report_valid_q <= 1'b0;
			report_q       <= '0;
		end else begin
			report_valid_q <= 1'b0;
			cmp_vld_s1     <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (load_ok) begin
						active_q[load_idx] <= (command.burst_length != 16'd0);
					end
					if (tick_take) begin
						now_q    <= time_q;
						ended_q  <= (time_q == TIME_MAX) ? TIME_MAX : time_q + 16'd1;
						rd_idx_q <= '0;
						fin_q    <= 1'b0;
						turn_q   <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= 1'b1;
					cmp_idx_s1 <= rd_idx_q;
					if (rd_idx_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + SLOT_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_READ_REM;
				end
				ST_READ_REM: begin
					state_q <= pick.found ? ST_UPDATE : ST_REPORT;
				end
				ST_UPDATE: begin
					fin_q              <= (rem_rd == 16'd1);
					active_q[pick.idx] <= (rem_dec != 16'd0);
					turn_q             <= sub_d[15:0];
					state_q            <= ST_REPORT;
				end
				ST_REPORT: begin
					report_valid_q        <= 1'b1;
					report_q.tick_time    <= now_q;
					report_q.running_slot <= pick.found ? 4'(pick.idx) : 4'd0;
					report_q.idle         <= !pick.found;
					report_q.switched     <= sw;
					report_q.finished     <= fin_q;
					report_q.turnaround   <= fin_q ? turn_q : 16'd0;
					report_q.wait_ticks   <= fin_q ? wait_val : 16'd0;
					report_q.all_done     <= (active_q == '0);
					prev_vld_q            <= pick.found;
					prev_idx_q            <= pick.idx;
					time_q                <= ended_q;
					state_q               <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign report_valid = report_valid_q;
	assign report       = report_q;

	// Report strobe lasts a single cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |=> !report_valid)
		else $error("report strobe held for more than one cycle");

	// An idle tick neither switches nor finishes a task
	assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && report.idle) |-> (!report.switched && !report.finished))
		else $error("idle report carries task activity");

	// An accepted tick makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command.operation == OP_TICK) |=> busy)
		else $error("tick transaction did not start the sequencer");

	// A finished task leaves no work on its slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT && fin_q) |-> !active_q[pick.idx])
		else $error("finished slot still marked active");

	// Report timestamps the time held at the start of the tick
	assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> (report.tick_time == now_q))
		else $error("report time differs from tick start time");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the preemptive priority scheduler: directed and random runs.
`timescale 1ns / 1ps
module tb_top;
	import pps_pkg::*;

	localparam int          RANDOM_ITEMS        = 1650;
	localparam int          SETTLE_CYCLES       = SLOTS + 8;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     start        = 1'b0;
	command_t command      = '0;
	logic     busy;
	logic     report_valid;
	report_t  report;

	// Mirrored scheduler state
	logic [15:0]              task_arrival [SLOTS] = '{default: '0};
	logic [15:0]              task_burst   [SLOTS] = '{default: '0};
	logic [PRIORITY_BITS-1:0] task_prio    [SLOTS] = '{default: '0};
	logic [15:0]              task_left    [SLOTS] = '{default: '0};
	logic [15:0]              sched_time   = '0;
	logic [SLOT_W-1:0]        last_slot    = '0;
	logic                     last_ran     = 1'b0;

	report_t pending_reports [$];
	int      mismatch_count = 0;
	int      items_sent     = 0;
	int      burst_left     = 0;

	preemptive_priority_scheduler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.report_valid(report_valid),
		.report      (report)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one accepted transaction to the mirrored state; return 1 when it yields a report
	function automatic bit schedule_command(input command_t c, output report_t r);
		logic [15:0] now;
		logic [15:0] ended;
		logic [15:0] turn;
		int          best;
		bit          found;
		bit          pending;
		r = '0;
		if (c.operation == OP_LOAD) begin
			if (int'(c.slot) < SLOTS) begin
				task_arrival[c.slot] = c.arrival_time;
				task_burst[c.slot]   = c.burst_length;
				task_prio[c.slot]    = c.priority_level[PRIORITY_BITS-1:0];
				task_left[c.slot]    = c.burst_length;
			end
			return 1'b0;
		end
		now   = sched_time;
		best  = 0;
		found = 1'b0;
		// Pick the ready slot with the lowest priority number, then earliest arrival, then lowest index
		for (int i = 0; i < SLOTS; i++) begin
			if (task_left[i] != 0 && task_arrival[i] <= now) begin
				if (!found || task_prio[i] < task_prio[best] ||
				    (task_prio[i] == task_prio[best] && task_arrival[i] < task_arrival[best])) begin
					best  = i;
					found = 1'b1;
				end
			end
		end
		// Saturate the clock at its maximum
		ended = (now == TIME_MAX) ? now : now + 16'd1;
		r.tick_time = now;
		r.idle      = !found;
		if (found) begin
			task_left[best]--;
			r.running_slot = SLOT_W'(best);
			r.switched     = !last_ran || last_slot != SLOT_W'(best);
			if (task_left[best] == 0) begin
				turn         = ended - task_arrival[best];
				r.finished   = 1'b1;
				r.turnaround = turn;
				r.wait_ticks = (turn >= task_burst[best]) ? turn - task_burst[best] : '0;
			end
			last_slot = SLOT_W'(best);
			last_ran  = 1'b1;
		end else begin
			last_ran = 1'b0;
		end
		pending = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			if (task_left[i] != 0)
				pending = 1'b1;
		r.all_done = !pending;
		sched_time = ended;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Check each report against the oldest prediction, then predict the accepted transaction
	always @(posedge clk) begin : report_check
		report_t predicted;
		report_t oldest;
		if (arst_n) begin
			if (report_valid) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none, got %h", $time, report);
					mismatch_count++;
				end else begin
					oldest = pending_reports.pop_front();
					check_field("tick_time", oldest.tick_time, report.tick_time);
					check_field("running_slot", oldest.running_slot, report.running_slot);
					check_field("idle", oldest.idle, report.idle);
					check_field("switched", oldest.switched, report.switched);
					check_field("finished", oldest.finished, report.finished);
					check_field("turnaround", oldest.turnaround, report.turnaround);
					check_field("wait_ticks", oldest.wait_ticks, report.wait_ticks);
					check_field("all_done", oldest.all_done, report.all_done);
				end
			end
			if (start && !busy) begin
				if (schedule_command(command, predicted))
					pending_reports.push_back(predicted);
			end
		end
	end

	// Insert a random gap when the current burst runs out, then hold the transaction until taken
	task automatic send_command(input command_t c);
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(0, 6);
		end
		start   <= 1'b1;
		command <= c;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic send_load(input int s, input logic [15:0] a, b, input logic [7:0] p);
		command_t c;
		c.operation      = OP_LOAD;
		c.slot           = SLOT_W'(s);
		c.arrival_time   = a;
		c.burst_length   = b;
		c.priority_level = p;
		send_command(c);
	endtask

	// Unused fields of a tick carry random junk
	task automatic send_tick();
		command_t c;
		c.operation      = OP_TICK;
		c.slot           = 4'($urandom);
		c.arrival_time   = 16'($urandom);
		c.burst_length   = 16'($urandom);
		c.priority_level = 8'($urandom);
		send_command(c);
	endtask

	task automatic clear_slots();
		for (int s = 0; s < SLOTS; s++)
			send_load(s, 16'($urandom), 16'd0, 8'($urandom));
	endtask

	// Idle ticks straight after reset
	task automatic test_idle_after_reset();
		send_tick();
		send_tick();
	endtask

	// Priority, arrival and index tie-breaks, plus preemption by a late load
	task automatic test_priority_order();
		send_load(15, 16'd0, 16'd2, 8'd255);
		send_load(12, 16'd1, 16'd1, 8'd7);
		send_load(6, 16'd2, 16'd1, 8'd7);
		send_load(2, 16'd2, 16'd1, 8'd7);
		send_tick();
		send_load(4, 16'd0, 16'd1, 8'd0);
		repeat (5) send_tick();
	endtask

	// Reload a running slot and load an empty one
	task automatic test_reload_and_empty();
		send_load(3, 16'd0, 16'd5, 8'd3);
		send_tick();
		send_load(3, 16'd0, 16'd1, 8'd3);
		send_tick();
		send_load(8, 16'd0, 16'd0, 8'd0);
		send_tick();
	endtask

	// A task that never arrives keeps all_done low until it is emptied
	task automatic test_unreachable_arrival();
		send_load(1, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_tick();
		send_load(1, 16'd0, 16'd0, 8'd0);
		send_tick();
	endtask

	// Mostly well-formed task sets with random content; the rest noise and broken sequences
	task automatic test_random_schedules();
		int          first_item;
		int          work;
		logic [15:0] b;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			case ($urandom_range(0, 11))
				0: send_load(int'($urandom_range(0, SLOTS - 1)), 16'($urandom), 16'($urandom),
				             8'($urandom));
				1: clear_slots();
				2: repeat ($urandom_range(1, 6)) send_tick();
				default: begin
					work = 0;
					repeat ($urandom_range(1, 5)) begin
						b = 16'($urandom_range(1, 6));
						work += int'(b) + 2;
						send_load(int'($urandom_range(0, SLOTS - 1)),
						          16'(sched_time + $urandom_range(0, 6)), b,
						          ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3))
						                                      : 8'($urandom));
					end
					repeat (work + $urandom_range(0, 4)) begin
						if ($urandom_range(0, 7) == 0)
							send_load(int'($urandom_range(0, SLOTS - 1)), sched_time,
							          16'($urandom_range(1, 3)), 8'($urandom_range(0, 1)));
						send_tick();
					end
				end
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_after_reset();
		test_priority_order();
		test_reload_and_empty();
		test_unreachable_arrival();
		test_random_schedules();
		start <= 1'b0;
		// Drain outstanding reports, then watch for stray ones
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("preemptive_priority_scheduler regression: pass");
		else
			$display("preemptive_priority_scheduler regression: fail");
		$finish;
	end

	// Give up well beyond the slowest correct run
	initial begin
		#150_000_000;
		$display("preemptive_priority_scheduler regression: fail");
		$finish;
	end

endmodule

FILE: files.f
sv/pps_pkg.sv
sv/pps_ram.sv
sv/pps_pick.sv
sv/preemptive_priority_scheduler.sv
bench/tb_top.sv
